// File: src/java_lcg_random_generator_assert.svh
// ----------------------------------------------------------------------------
// java_lcg_random_generator_assert.svh
// assertion macros for the lcg generator
// ----------------------------------------------------------------------------
`ifndef JAVA_LCG_RANDOM_GENERATOR_ASSERT_SVH
`define JAVA_LCG_RANDOM_GENERATOR_ASSERT_SVH

`ifndef SYNTHESIS
`define JLCG_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("jlcg assertion failed");
`define JLCG_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("jlcg assertion failed");
`else
`define JLCG_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define JLCG_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// File: src/jlcg_pkg.sv
// ----------------------------------------------------------------------------
// jlcg_pkg
// types and constants of the 48-bit lcg generator
// ----------------------------------------------------------------------------
package jlcg_pkg;

	localparam int unsigned LCG_BITS = 48;

	localparam logic [LCG_BITS-1:0] LCG_MULT = 48'h0005_DEEC_E66D;
	localparam logic [LCG_BITS-1:0] LCG_ADD  = 48'h0000_0000_000B;

	typedef enum logic [3:0] {
		CMD_BITS      = 4'd0,
		CMD_INT       = 4'd1,
		CMD_BOUNDED   = 4'd2,
		CMD_LONG      = 4'd3,
		CMD_FLOAT     = 4'd4,
		CMD_DOUBLE    = 4'd5,
		CMD_SEED      = 4'd6,
		CMD_RAW_SEED  = 4'd7,
		CMD_READ_SEED = 4'd8
	} cmd_t;

	typedef enum logic [1:0] {
		STATUS_OK        = 2'd0,
		STATUS_BAD_BITS  = 2'd1,
		STATUS_BAD_BOUND = 2'd2
	} status_t;

endpackage

// File: src/jlcg_if.sv
// ----------------------------------------------------------------------------
// jlcg_if
// request and response channels of the lcg generator
// ----------------------------------------------------------------------------
interface jlcg_req_if;
	logic        valid;
	logic        ready;
	logic [3:0]  command;
	logic [5:0]  bit_count;
	logic signed [31:0] bound;
	logic signed [63:0] seed_value;

	modport source (output valid, command, bit_count, bound, seed_value, input ready);
	modport sink (input valid, command, bit_count, bound, seed_value, output ready);
endinterface

interface jlcg_rsp_if;
	logic        valid;
	logic        ready;
	logic signed [63:0] value;
	logic [1:0]  status;

	modport source (output valid, value, status, input ready);
	modport sink (input valid, value, status, output ready);
endinterface

// File: src/java_lcg_random_generator.sv
// ----------------------------------------------------------------------------
// java_lcg_random_generator
// 48-bit linear congruential generator with draw, seed and read commands
//
//   channel  dir  payload                                  beat when
//   req      in   command, bit_count, bound, seed_value    valid & ready
//   rsp      out  value, status                            valid & ready
//
// a state step runs ST_MUL_LO, ST_MUL_HI, ST_STEP on the one shared 32x32
// multiplier; single-draw commands step the state once, two-draw twice, and
// a power-of-two bound adds ST_MUL_BND, others 31 divider steps and a check
// per draw, repeated on rejection; seed, read and error beats go to ST_FINISH
// reset loads the scrambled zero seed; a stalled rsp holds the next result
// ----------------------------------------------------------------------------
`include "java_lcg_random_generator_assert.svh"

module java_lcg_random_generator (
	input  logic        clk,
	input  logic        arst_n,
	jlcg_req_if.sink    req,
	jlcg_rsp_if.source  rsp
);

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MUL_LO,
		ST_MUL_HI,
		ST_STEP,
		ST_USE,
		ST_MUL_BND,
		ST_DIV,
		ST_CHECK,
		ST_FINISH
	} state_t;

	localparam int unsigned LB = jlcg_pkg::LCG_BITS;

	state_t                  state_q;
	logic [LB-1:0]           lcg_q;
	jlcg_pkg::cmd_t          cmd_q;
	logic [5:0]              nbits_q;
	logic [31:0]             bound_q;
	logic                    second_q;
	logic [31:0]             hi_q;
	logic [63:0]             prod_q;
	logic [15:0]             cross_q;
	logic [30:0]             b_q;
	logic [30:0]             dsh_q;
	logic [30:0]             rem_q;
	logic [4:0]              cnt_q;
	logic [63:0]             res_value_q;
	logic [1:0]              res_status_q;
	logic                    rsp_valid_q;
	logic [63:0]             rsp_value_q;
	logic [1:0]              rsp_status_q;

	logic                    req_beat;
	jlcg_pkg::cmd_t          req_cmd;
	logic [31:0]             req_bound;
	logic                    bound_ok;
	logic                    bits_ok;
	logic                    seed_beat;

	logic [31:0]             mul_a;
	logic [31:0]             mul_b;
	logic [63:0]             mul_p;
	logic [15:0]             cross_sum;

	logic [31:0]             take_n;
	logic [31:0]             take32;
	logic [63:0]             long_sum;

	logic [31:0]             div_try;
	logic                    div_ge;
	logic [30:0]             div_rem;
	logic [32:0]             rej_sum;
	logic                    rejected;

	assign req.ready   = (state_q == ST_IDLE);
	assign req_beat    = req.valid && req.ready;
	assign req_cmd     = jlcg_pkg::cmd_t'(req.command);
	assign req_bound   = req.bound;
	assign bound_ok    = (req_bound != 32'd0) && !req_bound[31];
	assign bits_ok     = (req.bit_count != 6'd0) && (req.bit_count <= 6'd32);
	assign seed_beat   = req_beat && ((req_cmd == jlcg_pkg::CMD_SEED) ||
		(req_cmd == jlcg_pkg::CMD_RAW_SEED));

	assign rsp.valid   = rsp_valid_q;
	assign rsp.value   = rsp_value_q;
	assign rsp.status  = rsp_status_q;

	// shared multiplier
	always_comb begin
		mul_a = 32'd0;
		mul_b = 32'd0;
		case (state_q)
			ST_MUL_LO: begin
				mul_a = lcg_q[31:0];
				mul_b = jlcg_pkg::LCG_MULT[31:0];
			end
			ST_MUL_HI: begin
				mul_a = {16'd0, lcg_q[LB-1:32]};
				mul_b = {16'd0, jlcg_pkg::LCG_MULT[15:0]};
			end
			ST_MUL_BND: begin
				mul_a = bound_q;
				mul_b = {1'b0, b_q};
			end
			default: begin
				mul_a = 32'd0;
				mul_b = 32'd0;
			end
		endcase
	end

	assign mul_p = mul_a * mul_b;

	// hi state x low mult half + low state x mult bits above 32 (value 5)
	assign cross_sum = mul_p[15:0] + {lcg_q[13:0], 2'b00} + lcg_q[15:0];

	assign take_n   = 32'(lcg_q >> (6'(LB) - nbits_q));
	assign take32   = lcg_q[LB-1:LB-32];
	assign long_sum = {hi_q, 32'd0} + {{32{take32[31]}}, take32};

	// restoring divider step
	assign div_try = {rem_q, dsh_q[30]};
	assign div_ge  = (div_try >= bound_q);
	assign div_rem = div_ge ? 31'(div_try - bound_q) : div_try[30:0];

	assign rej_sum  = {2'b00, b_q} - {2'b00, rem_q} + {1'b0, bound_q} - 33'd1;
	assign rejected = (rej_sum[32:31] != 2'b00);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			lcg_q        <= jlcg_pkg::LCG_MULT;
			cmd_q        <= jlcg_pkg::CMD_BITS;
			nbits_q      <= 6'd0;
			bound_q      <= 32'd0;
			second_q     <= 1'b0;
			hi_q         <= 32'd0;
			prod_q       <= 64'd0;
			cross_q      <= 16'd0;
			b_q          <= 31'd0;
			dsh_q        <= 31'd0;
			rem_q        <= 31'd0;
			cnt_q        <= 5'd0;
			res_value_q  <= 64'd0;
			res_status_q <= jlcg_pkg::STATUS_OK;
			rsp_valid_q  <= 1'b0;
			rsp_value_q  <= 64'd0;
			rsp_status_q <= jlcg_pkg::STATUS_OK;
		end else begin
			if (rsp.ready && (state_q != ST_FINISH)) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (req_beat) begin
						cmd_q        <= req_cmd;
						nbits_q      <= req.bit_count;
						bound_q      <= req_bound;
						second_q     <= 1'b0;
						res_value_q  <= 64'd0;
						res_status_q <= jlcg_pkg::STATUS_OK;
						state_q      <= ST_FINISH;
						case (req_cmd)
							jlcg_pkg::CMD_BITS: begin
								if (bits_ok) begin
									state_q <= ST_MUL_LO;
								end else begin
									res_status_q <= jlcg_pkg::STATUS_BAD_BITS;
								end
							end
							jlcg_pkg::CMD_BOUNDED: begin
								if (bound_ok) begin
									state_q <= ST_MUL_LO;
								end else begin
									res_status_q <= jlcg_pkg::STATUS_BAD_BOUND;
								end
							end
							jlcg_pkg::CMD_INT, jlcg_pkg::CMD_LONG,
							jlcg_pkg::CMD_FLOAT, jlcg_pkg::CMD_DOUBLE: begin
								state_q <= ST_MUL_LO;
							end
							jlcg_pkg::CMD_SEED: begin
								lcg_q <= req.seed_value[LB-1:0] ^ jlcg_pkg::LCG_MULT;
							end
							jlcg_pkg::CMD_RAW_SEED: begin
								lcg_q <= req.seed_value[LB-1:0];
							end
							jlcg_pkg::CMD_READ_SEED: begin
								res_value_q <= {{(64-LB){1'b0}}, lcg_q};
							end
							default: begin
								state_q <= ST_FINISH;
							end
						endcase
					end
				end
				ST_MUL_LO: begin
					prod_q  <= mul_p;
					state_q <= ST_MUL_HI;
				end
				ST_MUL_HI: begin
					cross_q <= cross_sum;
					state_q <= ST_STEP;
				end
				ST_STEP: begin
					lcg_q   <= prod_q[LB-1:0] + {cross_q, 32'd0} + jlcg_pkg::LCG_ADD;
					state_q <= ST_USE;
				end
				ST_USE: begin
					state_q <= ST_FINISH;
					case (cmd_q)
						jlcg_pkg::CMD_BITS: begin
							res_value_q <= {{32{take_n[31]}}, take_n};
						end
						jlcg_pkg::CMD_INT: begin
							res_value_q <= {{32{take32[31]}}, take32};
						end
						jlcg_pkg::CMD_FLOAT: begin
							res_value_q <= {40'd0, lcg_q[LB-1:LB-24]};
						end
						jlcg_pkg::CMD_LONG: begin
							if (!second_q) begin
								hi_q     <= take32;
								second_q <= 1'b1;
								state_q  <= ST_MUL_LO;
							end else begin
								res_value_q <= long_sum;
							end
						end
						jlcg_pkg::CMD_DOUBLE: begin
							if (!second_q) begin
								hi_q     <= {6'd0, lcg_q[LB-1:LB-26]};
								second_q <= 1'b1;
								state_q  <= ST_MUL_LO;
							end else begin
								res_value_q <= {11'd0, hi_q[25:0], lcg_q[LB-1:LB-27]};
							end
						end
						jlcg_pkg::CMD_BOUNDED: begin
							b_q   <= lcg_q[LB-1:LB-31];
							dsh_q <= lcg_q[LB-1:LB-31];
							rem_q <= 31'd0;
							cnt_q <= 5'd30;
							if ((bound_q & (bound_q - 32'd1)) == 32'd0) begin
								state_q <= ST_MUL_BND;
							end else begin
								state_q <= ST_DIV;
							end
						end
						default: begin
							state_q <= ST_FINISH;
						end
					endcase
				end
				ST_MUL_BND: begin
					res_value_q <= {31'd0, mul_p[63:31]};
					state_q     <= ST_FINISH;
				end
				ST_DIV: begin
					rem_q <= div_rem;
					dsh_q <= {dsh_q[29:0], 1'b0};
					cnt_q <= cnt_q - 5'd1;
					if (cnt_q == 5'd0) begin
						state_q <= ST_CHECK;
					end
				end
				ST_CHECK: begin
					if (rejected) begin
						state_q <= ST_MUL_LO;
					end else begin
						res_value_q <= {33'd0, rem_q};
						state_q     <= ST_FINISH;
					end
				end
				ST_FINISH: begin
					if (!rsp_valid_q || rsp.ready) begin
						rsp_valid_q  <= 1'b1;
						rsp_value_q  <= res_value_q;
						rsp_status_q <= res_status_q;
						state_q      <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	`JLCG_ASSERT_NEXT(a_state_held, clk, arst_n, (state_q != ST_STEP) && !seed_beat, $stable(lcg_q))
	`JLCG_ASSERT_IMPL(a_rem_below_bound, clk, arst_n, state_q == ST_CHECK, 32'(rem_q) < bound_q)
	`JLCG_ASSERT_IMPL(a_pow2_bound, clk, arst_n, state_q == ST_MUL_BND, $onehot(bound_q))

endmodule

// File: bench/tb_java_lcg_random_generator.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_java_lcg_random_generator
// checks the 48-bit lcg generator against a predictor kept in step with it
//
// every request beat is run through a local copy of the generator state and
// the expected result is queued; each response beat is compared field by
// field with the oldest entry. directed beats cover bit counts, bounds,
// seeding and unused codes, then a long response hold-off, then random beats
// with random idling on both channels and a full drain in between
// ----------------------------------------------------------------------------
module tb_java_lcg_random_generator;

	localparam logic [3:0] CMD_UNUSED_FIRST = 4'd9;
	localparam logic [3:0] CMD_UNUSED_LAST  = 4'd15;
	localparam int         RANDOM_BEATS     = 1450;

	typedef struct {
		logic [3:0]         command;
		logic [5:0]         bit_count;
		logic signed [31:0] bound;
		logic signed [63:0] seed_value;
	} gen_request_t;

	typedef struct {
		logic signed [63:0] value;
		jlcg_pkg::status_t  status;
	} gen_result_t;

	logic clk;
	logic arst_n;

	jlcg_req_if req_ch();
	jlcg_rsp_if rsp_ch();

	java_lcg_random_generator DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	logic [jlcg_pkg::LCG_BITS-1:0] gen_state;
	gen_result_t         pending_results[$];
	gen_result_t         oldest_result;
	int                  mismatch_count;
	int                  result_count;
	int                  rsp_hold_left;
	bit                  sender_idles;
	bit                  rsp_idles;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#8_000_000;
		$display("java_lcg_random_generator verification failed");
		$finish;
	end

	function automatic logic [63:0] widen_signed(logic [31:0] w);
		return {{32{w[31]}}, w};
	endfunction

	// one state step, top n bits of the new state
	function automatic logic [31:0] next_draw(int unsigned n);
		gen_state = gen_state * jlcg_pkg::LCG_MULT + jlcg_pkg::LCG_ADD;
		return 32'(gen_state >> (jlcg_pkg::LCG_BITS - n));
	endfunction

	function automatic gen_result_t predict_result(gen_request_t r);
		gen_result_t res;
		logic [31:0] bnd32;
		logic [31:0] draw_a;
		logic [31:0] draw_b;
		logic [31:0] rem;
		logic [63:0] total;
		res.value = '0;
		res.status = jlcg_pkg::STATUS_OK;
		bnd32 = r.bound;
		case (r.command)
		jlcg_pkg::CMD_BITS: begin
			if (r.bit_count == 0 || r.bit_count > 32)
				res.status = jlcg_pkg::STATUS_BAD_BITS;
			else
				res.value = widen_signed(next_draw(r.bit_count));
		end
		jlcg_pkg::CMD_INT: begin
			res.value = widen_signed(next_draw(32));
		end
		jlcg_pkg::CMD_BOUNDED: begin
			if (r.bound <= 0) begin
				res.status = jlcg_pkg::STATUS_BAD_BOUND;
			end else if ((bnd32 & (bnd32 - 32'd1)) == 0) begin
				draw_a = next_draw(31);
				res.value = ({32'd0, bnd32} * {32'd0, draw_a}) >> 31;
			end else begin
				// rejection loop draws fresh states
				do begin
					draw_a = next_draw(31);
					rem = draw_a % bnd32;
					total = {32'd0, draw_a} - {32'd0, rem} + {32'd0, bnd32} - 64'd1;
				end while (total > 64'h7FFF_FFFF);
				res.value = {32'd0, rem};
			end
		end
		jlcg_pkg::CMD_LONG: begin
			draw_a = next_draw(32);
			draw_b = next_draw(32);
			res.value = {draw_a, 32'd0} + widen_signed(draw_b);
		end
		jlcg_pkg::CMD_FLOAT: begin
			res.value = {32'd0, next_draw(24)};
		end
		jlcg_pkg::CMD_DOUBLE: begin
			draw_a = next_draw(26);
			draw_b = next_draw(27);
			res.value = ({32'd0, draw_a} << 27) + {32'd0, draw_b};
		end
		jlcg_pkg::CMD_SEED: begin
			gen_state = r.seed_value[jlcg_pkg::LCG_BITS-1:0] ^ jlcg_pkg::LCG_MULT;
		end
		jlcg_pkg::CMD_RAW_SEED: begin
			gen_state = r.seed_value[jlcg_pkg::LCG_BITS-1:0];
		end
		jlcg_pkg::CMD_READ_SEED: begin
			res.value = {16'd0, gen_state};
		end
		default: begin
		end
		endcase
		return res;
	endfunction

	task automatic report_mismatch(string msg);
		mismatch_count++;
		$display("MISMATCH @%0t result %0d: %s", $time, result_count, msg);
	endtask

	always @(posedge clk) begin
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (pending_results.size() == 0) begin
				report_mismatch("response beat with nothing outstanding");
			end else begin
				oldest_result = pending_results.pop_front();
				if (rsp_ch.value !== oldest_result.value)
					report_mismatch($sformatf("value %h, expected %h",
						rsp_ch.value, oldest_result.value));
				if (rsp_ch.status !== oldest_result.status)
					report_mismatch($sformatf("status %0d, expected %0d",
						rsp_ch.status, oldest_result.status));
			end
			result_count++;
		end
	end

	// response side: long hold-off when asked, otherwise random idling while rsp_idles is set
	initial begin
		rsp_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (rsp_hold_left > 0) begin
				rsp_ch.ready <= 1'b0;
				rsp_hold_left--;
			end else begin
				rsp_ch.ready <= !rsp_idles || ($urandom_range(0, 99) >= 19);
			end
		end
	end

	task automatic send_beat(gen_request_t r);
		@(negedge clk);
		while (sender_idles && $urandom_range(0, 99) < 19) begin
			req_ch.valid <= 1'b0;
			@(negedge clk);
		end
		req_ch.valid      <= 1'b1;
		req_ch.command    <= r.command;
		req_ch.bit_count  <= r.bit_count;
		req_ch.bound      <= r.bound;
		req_ch.seed_value <= r.seed_value;
		do @(posedge clk); while (!req_ch.ready);
		pending_results.push_back(predict_result(r));
	endtask

	task automatic send_cmd(logic [3:0] cmd, logic [5:0] bits, logic signed [31:0] bnd,
			logic signed [63:0] seed);
		gen_request_t r;
		r.command = cmd;
		r.bit_count = bits;
		r.bound = bnd;
		r.seed_value = seed;
		send_beat(r);
	endtask

	task automatic wait_drained();
		@(negedge clk);
		req_ch.valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
	endtask

	function automatic gen_request_t random_request();
		gen_request_t r;
		int unsigned pick;
		int unsigned sub;
		r.command = jlcg_pkg::CMD_READ_SEED;
		r.bit_count = 6'($urandom);
		r.bound = $urandom;
		r.seed_value = {$urandom, $urandom};
		pick = $urandom_range(0, 99);
		sub = $urandom_range(0, 99);
		if (pick < 14) begin
			r.command = jlcg_pkg::CMD_BITS;
			if (sub < 88)
				r.bit_count = 6'($urandom_range(1, 32));
			else if (sub < 92)
				r.bit_count = 6'd0;
			else
				r.bit_count = 6'($urandom_range(33, 63));
		end else if (pick < 24) begin
			r.command = jlcg_pkg::CMD_INT;
		end else if (pick < 44) begin
			r.command = jlcg_pkg::CMD_BOUNDED;
			if (sub < 25)
				r.bound = 1 << $urandom_range(0, 30);
			else if (sub < 50)
				r.bound = $urandom_range(1, 1000);
			else if (sub < 80)
				r.bound = $urandom_range(1, 32'h7FFF_FFFF);
			else if (sub < 94)
				r.bound = $urandom_range(32'h4000_0001, 32'h7FFF_FFFF);
			else if (sub < 97)
				r.bound = 0;
			else
				r.bound = {1'b1, 31'($urandom)};
		end else if (pick < 54) begin
			r.command = jlcg_pkg::CMD_LONG;
		end else if (pick < 64) begin
			r.command = jlcg_pkg::CMD_FLOAT;
		end else if (pick < 74) begin
			r.command = jlcg_pkg::CMD_DOUBLE;
		end else if (pick < 82) begin
			r.command = jlcg_pkg::CMD_SEED;
		end else if (pick < 87) begin
			r.command = jlcg_pkg::CMD_RAW_SEED;
		end else if (pick < 96) begin
			r.command = jlcg_pkg::CMD_READ_SEED;
		end else begin
			r.command = 4'($urandom_range(CMD_UNUSED_FIRST, CMD_UNUSED_LAST));
		end
		return r;
	endfunction

	task automatic test_reset_seed();
		send_cmd(jlcg_pkg::CMD_READ_SEED, 6'd0, 32'sd0, 64'sd0);
	endtask

	task automatic test_bit_counts();
		send_cmd(jlcg_pkg::CMD_BITS, 6'd1, 32'sd0, 64'sd0);
		send_cmd(jlcg_pkg::CMD_BITS, 6'd31, 32'sd0, 64'sd0);
		send_cmd(jlcg_pkg::CMD_BITS, 6'd32, 32'sd0, 64'sd0);
		send_cmd(jlcg_pkg::CMD_BITS, 6'd0, 32'sd0, 64'sd0);
		send_cmd(jlcg_pkg::CMD_BITS, 6'd33, 32'sd0, 64'sd0);
		send_cmd(jlcg_pkg::CMD_BITS, 6'd63, 32'sd0, 64'sd0);
	endtask

	task automatic test_draws();
		send_cmd(jlcg_pkg::CMD_INT, 6'h3F, -32'sd1, -64'sd1);
		send_cmd(jlcg_pkg::CMD_LONG, 6'd0, 32'sd0, 64'sd0);
		send_cmd(jlcg_pkg::CMD_FLOAT, 6'd0, 32'sd0, 64'sd0);
		send_cmd(jlcg_pkg::CMD_DOUBLE, 6'd0, 32'sd0, 64'sd0);
	endtask

	task automatic test_bounds();
		send_cmd(jlcg_pkg::CMD_BOUNDED, 6'd0, 32'sd1, 64'sd0);
		send_cmd(jlcg_pkg::CMD_BOUNDED, 6'd0, 32'sd2, 64'sd0);
		send_cmd(jlcg_pkg::CMD_BOUNDED, 6'd0, 32'sh4000_0000, 64'sd0);
		send_cmd(jlcg_pkg::CMD_BOUNDED, 6'd0, 32'sd3, 64'sd0);
		send_cmd(jlcg_pkg::CMD_BOUNDED, 6'd0, 32'sh7FFF_FFFF, 64'sd0);
		send_cmd(jlcg_pkg::CMD_BOUNDED, 6'd0, 32'sh6000_0001, 64'sd0);
		send_cmd(jlcg_pkg::CMD_BOUNDED, 6'd0, 32'sd0, 64'sd0);
		send_cmd(jlcg_pkg::CMD_BOUNDED, 6'd0, -32'sd1, 64'sd0);
		send_cmd(jlcg_pkg::CMD_BOUNDED, 6'd0, 32'sh8000_0000, 64'sd0);
	endtask

	task automatic test_seeding();
		send_cmd(jlcg_pkg::CMD_SEED, 6'd0, 32'sd0, -64'sd1);
		send_cmd(jlcg_pkg::CMD_READ_SEED, 6'd0, 32'sd0, 64'sd0);
		send_cmd(jlcg_pkg::CMD_RAW_SEED, 6'd0, 32'sd0, 64'sh8000_0000_0000_0000);
		send_cmd(jlcg_pkg::CMD_INT, 6'd0, 32'sd0, 64'sd0);
		send_cmd(jlcg_pkg::CMD_RAW_SEED, 6'd0, 32'sd0, -64'sd1);
		send_cmd(jlcg_pkg::CMD_READ_SEED, 6'd0, 32'sd0, 64'sd0);
		send_cmd(CMD_UNUSED_FIRST, 6'd32, 32'sd5, 64'sd0);
		send_cmd(CMD_UNUSED_LAST, 6'd32, 32'sd5, 64'sd0);
		send_cmd(jlcg_pkg::CMD_SEED, 6'd0, 32'sd0, 64'sd0);
		send_cmd(jlcg_pkg::CMD_READ_SEED, 6'd0, 32'sd0, 64'sd0);
	endtask

	// response held off while requests keep coming, so the input stalls
	task automatic test_backpressure();
		rsp_hold_left = 300;
		for (int i = 0; i < 24; i++)
			send_beat(random_request());
		wait_drained();
	endtask

	task automatic test_random();
		for (int i = 0; i < RANDOM_BEATS; i++) begin
			sender_idles = !(i >= 500 && i < 700);
			rsp_idles = sender_idles;
			if (i == 900)
				wait_drained();
			send_beat(random_request());
		end
		sender_idles = 1'b1;
		rsp_idles = 1'b1;
	endtask

	initial begin
		arst_n = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.command = '0;
		req_ch.bit_count = '0;
		req_ch.bound = '0;
		req_ch.seed_value = '0;
		gen_state = jlcg_pkg::LCG_MULT;
		mismatch_count = 0;
		result_count = 0;
		rsp_hold_left = 0;
		sender_idles = 1'b1;
		rsp_idles = 1'b1;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_reset_seed();
		test_bit_counts();
		test_draws();
		test_bounds();
		test_seeding();
		test_backpressure();
		test_random();

		wait_drained();
		repeat (60) @(posedge clk);
		if (mismatch_count == 0 && pending_results.size() == 0) begin
			$display("java_lcg_random_generator verification clean");
		end else begin
			$display("java_lcg_random_generator verification failed");
		end
		$finish;
	end

endmodule

// File: files.f
+incdir+src
src/jlcg_pkg.sv
src/jlcg_if.sv
src/java_lcg_random_generator.sv
bench/tb_java_lcg_random_generator.sv
